// ===== rtl/ohle_pkg.sv =====
// Shared types and codes for the ordered handle list engine.
// Holds action and status codes, stream field layout and control structs.
// Used by ohle_ctrl, ohle_dpath and ordered_handle_list_engine.
package ohle_pkg;

  // Action codes
  localparam logic [2:0] ACT_APPEND  = 3'd0;
  localparam logic [2:0] ACT_PREPEND = 3'd1;
  localparam logic [2:0] ACT_DELETE  = 3'd2;
  localparam logic [2:0] ACT_FIND    = 3'd3;
  localparam logic [2:0] ACT_REMOVE  = 3'd4;
  localparam logic [2:0] ACT_CLEAR   = 3'd5;
  localparam logic [2:0] ACT_READ    = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;

  // Controller to datapath commands
  typedef struct packed {
    logic start;   // capture request and set up the walk
    logic step;    // advance the walk by one entry
    logic finish;  // commit length and load the result register
  } ohle_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic busy;      // reads still to issue or in flight
    logic out_free;  // result register can take a new result
  } ohle_stat_t;

endpackage

// ===== rtl/ohle_ctrl.sv =====
// Controller state machine for the ordered handle list engine.
// Sequences accept, walk and result phases; depends on ohle_pkg.
module ohle_ctrl
  import ohle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  ohle_stat_t stat,
  output ohle_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Decode commands and next state
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (!stat.busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/ohle_dpath.sv =====
// Datapath for the ordered handle list engine: entry memory, walk counters,
// length register and result register. Depends on ohle_pkg.
module ohle_dpath
  import ohle_pkg::*;
#(
  parameter int CAPACITY    = 1024,
  parameter int ENTRY_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ohle_cmd_t              cmd,
  output ohle_stat_t             stat,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int EW = ENTRY_WIDTH;

  // Entry memory
  logic [EW-1:0] mem [CAPACITY];

  // Request and walk registers
  logic [2:0]    act;
  logic [EW-1:0] val;
  logic [9:0]    pos;
  logic [AW-1:0] idx;
  logic [LW-1:0] rem;
  logic          down;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic [EW-1:0] rdata;
  logic [LW-1:0] wcnt;
  logic          found;
  logic [AW-1:0] fpos;
  logic [EW-1:0] rd_data;
  logic [LW-1:0] len;

  // Incoming fields
  logic [2:0]    act_in;
  logic [63:0]   val_wide;
  logic [EW-1:0] val_in;
  logic [9:0]    pos_in;
  logic          full;
  logic          inrange_in;
  logic          inrange;

  // Walk setup
  logic [AW-1:0] idx_init;
  logic [LW-1:0] rem_init;

  // Memory write port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  // Finish values
  logic [LW-1:0] len_next;
  logic [1:0]    st_fin;
  logic [31:0]   fpos_fin;
  logic [63:0]   rd_fin;
  logic [31:0]   rem_cnt_fin;
  logic [31:0]   len_fin;

  assign act_in     = s_tdata[2:0];
  assign val_wide   = 64'(s_tdata[18:3]);
  assign val_in     = val_wide[EW-1:0];
  assign pos_in     = s_tdata[28:19];
  assign full       = 32'(len) >= CAPACITY;
  assign inrange_in = 32'(pos_in) < 32'(len);
  assign inrange    = 32'(pos) < 32'(len);

  assign stat.busy     = (rem != '0) || pend;
  assign stat.out_free = !m_tvalid || m_tready;

  // Set up the walk for the request
  always_comb begin
    idx_init = '0;
    rem_init = '0;
    case (act_in)
      ACT_PREPEND: begin
        if (!full) begin
          idx_init = AW'(len - LW'(1));
          rem_init = len;
        end
      end
      ACT_DELETE: begin
        if (inrange_in) begin
          idx_init = AW'(pos_in) + AW'(1);
          rem_init = LW'(32'(len) - 32'(pos_in) - 32'd1);
        end
      end
      ACT_FIND, ACT_REMOVE: begin
        rem_init = len;
      end
      ACT_READ: begin
        if (inrange_in) begin
          idx_init = AW'(pos_in);
          rem_init = LW'(1);
        end
      end
      default: begin
        rem_init = '0;
      end
    endcase
  end

  // Select the memory write: final insert on finish, else the walk's move
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rdata;
    if (cmd.finish) begin
      if (act == ACT_APPEND && !full) begin
        wr_en   = 1'b1;
        wr_addr = len[AW-1:0];
        wr_data = val;
      end else if (act == ACT_PREPEND && !full) begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = val;
      end
    end else if (pend) begin
      case (act)
        ACT_PREPEND: begin
          wr_en   = 1'b1;
          wr_addr = pend_addr + AW'(1);
        end
        ACT_DELETE: begin
          wr_en   = 1'b1;
          wr_addr = pend_addr - AW'(1);
        end
        ACT_REMOVE: begin
          wr_en   = rdata != val;
          wr_addr = wcnt[AW-1:0];
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // Memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.step && rem != '0) begin
      rdata <= mem[idx];
    end
  end

  // Capture the request, walk the entries and track matches
  always_ff @(posedge clk) begin
    if (rst) begin
      rem  <= '0;
      pend <= 1'b0;
    end else if (cmd.start) begin
      act   <= act_in;
      val   <= val_in;
      pos   <= pos_in;
      idx   <= idx_init;
      rem   <= rem_init;
      down  <= act_in == ACT_PREPEND;
      pend  <= 1'b0;
      wcnt  <= '0;
      found <= 1'b0;
      fpos  <= '0;
    end else begin
      // issue the next read
      if (cmd.step && rem != '0) begin
        pend      <= 1'b1;
        pend_addr <= idx;
        idx       <= down ? idx - AW'(1) : idx + AW'(1);
        rem       <= rem - LW'(1);
      end else begin
        pend <= 1'b0;
      end
      // consume the returning entry
      if (pend) begin
        if (act == ACT_FIND && !found && rdata == val) begin
          found <= 1'b1;
          fpos  <= pend_addr;
        end
        if (act == ACT_REMOVE && rdata != val) begin
          wcnt <= wcnt + LW'(1);
        end
        if (act == ACT_READ) begin
          rd_data <= rdata;
        end
      end
    end
  end

  // Work out the result and the new length
  always_comb begin
    len_next    = len;
    st_fin      = ST_OK;
    fpos_fin    = '0;
    rd_fin      = '0;
    rem_cnt_fin = '0;
    case (act)
      ACT_APPEND, ACT_PREPEND: begin
        if (full) begin
          st_fin = ST_FULL;
        end else begin
          len_next = len + LW'(1);
        end
      end
      ACT_DELETE: begin
        if (inrange) begin
          len_next    = len - LW'(1);
          rem_cnt_fin = 32'd1;
        end else begin
          st_fin = ST_RANGE;
        end
      end
      ACT_FIND: begin
        if (found) begin
          fpos_fin = 32'(fpos);
        end else begin
          st_fin = ST_NOTFOUND;
        end
      end
      ACT_REMOVE: begin
        len_next    = wcnt;
        rem_cnt_fin = 32'(len) - 32'(wcnt);
      end
      ACT_CLEAR: begin
        len_next = '0;
      end
      ACT_READ: begin
        if (inrange) begin
          rd_fin = 64'(rd_data);
        end else begin
          st_fin = ST_RANGE;
        end
      end
      default: begin
        st_fin = ST_OK;
      end
    endcase
  end

  assign len_fin = 32'(len_next);

  // Commit the length and hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      len      <= len_next;
      m_tvalid <= 1'b1;
      m_tdata  <= {6'd0, rem_cnt_fin[10:0], rd_fin[15:0], fpos_fin[9:0],
                   len_fin[10:0], st_fin};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== rtl/ordered_handle_list_engine.sv =====
// Ordered handle list engine: one result per request, in request order.
// Each request walks N stored entries, N = length for prepend, find and remove-all,
// length - position - 1 for delete and 1 for read; a stalled result port delays
// the result. One request at a time: the next is taken in the cycle after the finish
// command loads the result, and the walk of one stored entry per cycle sets the pace.
// Reset clears the length and the result valid flag; entries are not cleared.
module ordered_handle_list_engine
  import ohle_pkg::*;
#(
  parameter int CAPACITY    = 1024,
  parameter int ENTRY_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // action[2:0], entry_value[18:3], position[28:19], zero fill above
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status[1:0], list_length[12:2], found_position[22:13], entry_read[38:23],
  // removed_count[49:39], zero fill above
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  ohle_cmd_t  cmd;
  ohle_stat_t stat;

  ohle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ohle_dpath #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
